### sv/rhp_pkg.sv
// shared types and constants for the rtp header parser
// no dependencies
package rhp_pkg;

  // fixed header size and longest accepted datagram in bytes
  localparam int unsigned FixedHdr = 12;
  localparam int unsigned MaxLen   = 65535;

  // rtp version expected in the two top bits of byte 0
  localparam logic [1:0] RtpVersion = 2'd2;

  // result status codes, first failing check wins
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_VERSION  = 3'd2,
    ST_CSRC     = 3'd3,
    ST_EXT      = 3'd4,
    ST_PAD      = 3'd5,
    ST_EMPTY    = 3'd6,
    ST_TOO_LONG = 3'd7
  } rhp_status_e;

  // per-datagram summary handed from the byte front end to the checker
  typedef struct packed {
    logic [7:0]  flags;
    logic [7:0]  ptype;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [31:0] source;
    logic [15:0] ext_words;
    logic [16:0] total;
    logic [7:0]  pad;
    logic        too_long;
  } rhp_desc_t;

  // one finished result
  typedef struct packed {
    rhp_status_e status;
    logic        marker;
    logic [6:0]  ptype;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [31:0] source;
    logic [15:0] offset;
    logic [15:0] length;
  } rhp_result_t;

endpackage

### sv/rhp_front.sv
// byte front end: counts bytes, captures header words and extension length
// depends on rhp_pkg
module rhp_front import rhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output logic       desc_valid_o,
  output rhp_desc_t  desc_o
);

  logic [15:0] count_q, count_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] stamp_q, stamp_d;
  logic [31:0] source_q, source_d;
  logic [15:0] ext_q, ext_d;
  logic [7:0]  prev_q, prev_d;
  logic        long_q, long_d;

  logic [7:0]  cap_flags, cap_type;
  logic [15:0] cap_seq, cap_ext;
  logic [31:0] cap_stamp, cap_source;
  logic        cap_long;
  logic [6:0]  ext_at;
  logic        ext_hit;

  // extension length sits two and three bytes past the csrc list
  assign ext_at  = 7'(FixedHdr) + {1'b0, flags_q[3:0], 2'b00};
  assign ext_hit = flags_q[4] && (count_q >= 16'(FixedHdr)) &&
                   ((count_q == 16'(ext_at) + 16'd2) || (count_q == 16'(ext_at) + 16'd3));

  // capture of the current item into the header fields
  always_comb begin
    cap_flags  = flags_q;
    cap_type   = type_q;
    cap_seq    = seq_q;
    cap_stamp  = stamp_q;
    cap_source = source_q;
    cap_ext    = ext_q;
    cap_long   = long_q | ({1'b0, count_q} >= 17'(MaxLen));
    if (count_q == 16'd0) begin
      cap_flags = data_byte_i;
    end else if (count_q == 16'd1) begin
      cap_type = data_byte_i;
    end else if (count_q <= 16'd3) begin
      cap_seq = {seq_q[7:0], data_byte_i};
    end else if (count_q <= 16'd7) begin
      cap_stamp = {stamp_q[23:0], data_byte_i};
    end else if (count_q <= 16'd11) begin
      cap_source = {source_q[23:0], data_byte_i};
    end
    if (ext_hit) begin
      cap_ext = {ext_q[7:0], data_byte_i};
    end
  end

  // next state, cleared after the final byte
  always_comb begin
    count_d  = count_q;
    flags_d  = flags_q;
    type_d   = type_q;
    seq_d    = seq_q;
    stamp_d  = stamp_q;
    source_d = source_q;
    ext_d    = ext_q;
    prev_d   = prev_q;
    long_d   = long_q;
    if (accept_i) begin
      if (last_i) begin
        count_d  = '0;
        flags_d  = '0;
        type_d   = '0;
        seq_d    = '0;
        stamp_d  = '0;
        source_d = '0;
        ext_d    = '0;
        prev_d   = '0;
        long_d   = 1'b0;
      end else begin
        count_d  = (count_q != 16'hFFFF) ? count_q + 16'd1 : count_q;
        flags_d  = cap_flags;
        type_d   = cap_type;
        seq_d    = cap_seq;
        stamp_d  = cap_stamp;
        source_d = cap_source;
        ext_d    = cap_ext;
        prev_d   = data_byte_i;
        long_d   = cap_long;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      flags_q  <= '0;
      type_q   <= '0;
      seq_q    <= '0;
      stamp_q  <= '0;
      source_q <= '0;
      ext_q    <= '0;
      prev_q   <= '0;
      long_q   <= 1'b0;
    end else begin
      count_q  <= count_d;
      flags_q  <= flags_d;
      type_q   <= type_d;
      seq_q    <= seq_d;
      stamp_q  <= stamp_d;
      source_q <= source_d;
      ext_q    <= ext_d;
      prev_q   <= prev_d;
      long_q   <= long_d;
    end
  end

  // summary of the datagram on its final item; the final byte is the pad count
  assign desc_valid_o    = accept_i & last_i;
  assign desc_o.flags     = cap_flags;
  assign desc_o.ptype     = cap_type;
  assign desc_o.seq       = cap_seq;
  assign desc_o.stamp     = cap_stamp;
  assign desc_o.source    = cap_source;
  assign desc_o.ext_words = cap_ext;
  assign desc_o.total     = {1'b0, count_q} + 17'd1;
  assign desc_o.pad       = data_byte_i;
  assign desc_o.too_long  = cap_long;

endmodule

### sv/rhp_desc_queue.sv
// two-entry queue of datagram summaries between front end and checker
// depends on rhp_pkg
module rhp_desc_queue import rhp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rhp_desc_t data_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output rhp_desc_t data_o
);

  rhp_desc_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### sv/rhp_back.sv
// checker: two-stage pipeline that sizes the header and decides the status
// depends on rhp_pkg
module rhp_back import rhp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        desc_valid_i,
  input  rhp_desc_t   desc_i,
  output logic        desc_ready_o,
  input  logic        pop_i,
  output logic        res_valid_o,
  output rhp_result_t res_o
);

  // stage a: header size and early checks
  logic        a_valid_q;
  rhp_status_e a_status_q;
  logic [16:0] a_hdr_q;
  logic [17:0] a_tp_q;
  logic [16:0] a_total_q;
  logic        a_pad_en_q, a_pad_zero_q;
  logic        a_marker_q;
  logic [6:0]  a_ptype_q;
  logic [15:0] a_seq_q;
  logic [31:0] a_stamp_q, a_source_q;

  // stage b: finished result
  logic        b_valid_q;
  rhp_result_t b_res_q;

  logic        a_ready, b_ready, a_load;
  logic [6:0]  hdr_base;
  logic [18:0] ext_add, hdr_full, total_w;
  rhp_status_e a_status_d;
  logic [16:0] pay;
  logic [17:0] pay_pad;
  logic [16:0] pay_fin;
  rhp_status_e b_status_d;

  assign b_ready      = ~b_valid_q | pop_i;
  assign a_ready      = ~a_valid_q | b_ready;
  assign desc_ready_o = a_ready;
  assign a_load       = desc_valid_i & a_ready;

  // header size including csrc list and extension
  assign hdr_base = 7'(FixedHdr) + {1'b0, desc_i.flags[3:0], 2'b00};
  assign ext_add  = 19'd4 + {1'b0, desc_i.ext_words, 2'b00};
  assign hdr_full = 19'(hdr_base) + (desc_i.flags[4] ? ext_add : 19'd0);
  assign total_w  = {2'b00, desc_i.total};

  // early status checks in priority order
  always_comb begin
    if (desc_i.too_long) begin
      a_status_d = ST_TOO_LONG;
    end else if (desc_i.total < 17'(FixedHdr)) begin
      a_status_d = ST_SHORT;
    end else if (desc_i.flags[7:6] != RtpVersion) begin
      a_status_d = ST_VERSION;
    end else if (19'(hdr_base) > total_w) begin
      a_status_d = ST_CSRC;
    end else if (desc_i.flags[4] && (hdr_full > total_w)) begin
      a_status_d = ST_EXT;
    end else begin
      a_status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_status_q   <= a_status_d;
      a_hdr_q      <= hdr_full[16:0];
      a_tp_q       <= {1'b0, desc_i.total} - {10'b0, desc_i.pad};
      a_total_q    <= desc_i.total;
      a_pad_en_q   <= desc_i.flags[5];
      a_pad_zero_q <= (desc_i.pad == 8'd0);
      a_marker_q   <= desc_i.ptype[7];
      a_ptype_q    <= desc_i.ptype[6:0];
      a_seq_q      <= desc_i.seq;
      a_stamp_q    <= desc_i.stamp;
      a_source_q   <= desc_i.source;
    end
  end

  // payload size with padding removed
  assign pay     = a_total_q - a_hdr_q;
  assign pay_pad = a_tp_q - {1'b0, a_hdr_q};
  assign pay_fin = a_pad_en_q ? pay_pad[16:0] : pay;

  always_comb begin
    if (a_status_q != ST_OK) begin
      b_status_d = a_status_q;
    end else if (a_pad_en_q && (a_pad_zero_q || pay_pad[17])) begin
      b_status_d = ST_PAD;
    end else if (pay_fin == 17'd0) begin
      b_status_d = ST_EMPTY;
    end else begin
      b_status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      b_res_q.status <= b_status_d;
      b_res_q.marker <= a_marker_q;
      b_res_q.ptype  <= a_ptype_q;
      b_res_q.seq    <= a_seq_q;
      b_res_q.stamp  <= a_stamp_q;
      b_res_q.source <= a_source_q;
      b_res_q.offset <= (b_status_d == ST_OK) ? a_hdr_q[15:0] : 16'd0;
      b_res_q.length <= (b_status_d == ST_OK) ? pay_fin[15:0] : 16'd0;
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= desc_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  assign res_valid_o = b_valid_q;
  assign res_o       = b_res_q;

endmodule

### sv/rtp_header_parser_top.sv
// rtp header parser: one datagram byte per item in, one header summary out
// depends on rhp_pkg, rhp_front, rhp_desc_queue, rhp_back
//
// Input channel: a byte is taken on each clock edge with push high and
// full low; last marks the final byte of a datagram. The front end counts
// bytes and captures the fixed header and the extension length; on the
// final byte it writes a summary into a two-entry queue.
// Result channel: while empty is low the oldest result sits on the result
// ports; it is taken on an edge with pop high. One result per datagram.
// Throughput: one byte per cycle while full is low, including back-to-back
// datagrams; the checker takes one summary per cycle unless pop is held low.
// A final byte's summary is registered in the queue, then in the two checker
// stages of adders and compares, before its result appears.
// Stall: when pop is held low the checker stages and then the queue fill;
// full rises only when the queue holds two summaries, so bytes keep
// flowing through up to three waiting results.
// Reset: the byte count and captured header clear, the queue and checker
// empty; no clearing pass is needed.
module rtp_header_parser_top import rhp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic        marker_o,
  output logic [6:0]  payload_type_o,
  output logic [15:0] seq_number_o,
  output logic [31:0] time_stamp_o,
  output logic [31:0] source_id_o,
  output logic [15:0] payload_offset_o,
  output logic [15:0] payload_length_o
);

  logic        accept;
  logic        desc_push, q_full, q_valid, q_pop;
  rhp_desc_t   desc_in, desc_out;
  logic        res_valid;
  rhp_result_t res;

  assign accept = push & ~q_full;
  assign full   = q_full;

  // byte capture
  rhp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .desc_valid_o (desc_push),
    .desc_o       (desc_in)
  );

  // summary queue
  rhp_desc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .data_i  (desc_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (desc_out)
  );

  // header checker
  rhp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (q_valid),
    .desc_i       (desc_out),
    .desc_ready_o (q_pop),
    .pop_i        (pop),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result ports
  assign empty            = ~res_valid;
  assign status_o         = res.status;
  assign marker_o         = res.marker;
  assign payload_type_o   = res.ptype;
  assign seq_number_o     = res.seq;
  assign time_stamp_o     = res.stamp;
  assign source_id_o      = res.source;
  assign payload_offset_o = res.offset;
  assign payload_length_o = res.length;

endmodule
